// ===== sv/lfte_pkg.sv =====
`timescale 1ns / 1ps

package lfte_pkg;

	// Default geometry
	localparam int LINE_COLUMNS_DEF = 20;
	localparam int TAB_STOP_DEF     = 8;

	// Character codes
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_BLANK = 8'd32;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAB,
		ST_SCAN,
		ST_EMIT,
		ST_COPY
	} state_t;

	// Source of the line store write data
	typedef enum logic [1:0] {
		WR_INPUT,
		WR_BLANK,
		WR_COPY
	} wr_sel_t;

	// Source of the emit length
	typedef enum logic [1:0] {
		LEN_COL,
		LEN_COL1,
		LEN_BRK
	} len_sel_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic     store_we;
		wr_sel_t  wr_sel;
		logic     col_inc;
		logic     col_clr;
		logic     idx_scan;
		logic     idx_dec;
		logic     idx_inc;
		logic     emit_start;
		len_sel_t len_sel;
		logic     out_load;
		logic     out_nl;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic in_is_tab;
		logic in_is_nl;
		logic col_zero;
		logic col_last;
		logic col_over;
		logic tab_full;
		logic phase_end;
		logic scan_hit;
		logic emit_done;
		logic len_short;
		logic copy_last;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== sv/lfte_dp.sv =====
`timescale 1ns / 1ps

module lfte_dp #(
	parameter int LINE_COLUMNS = 20,
	parameter int TAB_STOP     = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_char,
	input  lfte_pkg::dp_cmd_t cmd,
	output lfte_pkg::dp_sts_t sts,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [7:0]        out_char,
	output logic              last_of_run
);
	import lfte_pkg::*;

	localparam int STORE_DEPTH = LINE_COLUMNS + TAB_STOP;
	localparam int IW          = $clog2(STORE_DEPTH);
	localparam int PW          = $clog2(TAB_STOP);

	localparam logic [IW-1:0] LC_I    = IW'(LINE_COLUMNS);
	localparam logic [IW-1:0] LC_M1   = IW'(LINE_COLUMNS - 1);
	localparam logic [PW-1:0] PH_LAST = PW'(TAB_STOP - 1);

	logic [7:0]    store_q [STORE_DEPTH];
	logic [IW-1:0] col_q;
	logic [PW-1:0] phase_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] idx_d;
	logic [IW-1:0] len_q;
	logic [IW-1:0] len_nxt;
	logic [7:0]    rd_q;
	logic [7:0]    rd_data;
	logic [7:0]    wr_data;
	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic          last_q;
	logic          out_free;

	// Single registered read port; always holds the entry at the scan/emit/copy pointer
	assign rd_data = rd_q;

	// Select write data
	always_comb begin
		case (cmd.wr_sel)
			WR_INPUT: wr_data = in_char;
			WR_BLANK: wr_data = CH_BLANK;
			WR_COPY:  wr_data = rd_data;
			default:  wr_data = in_char;
		endcase
	end

	// Write the line store at the column, read it at the next pointer
	always_ff @(posedge clk) begin
		if (cmd.store_we) begin
			store_q[col_q] <= wr_data;
		end
		// pass a write to the entry being read straight through
		if (cmd.store_we && (col_q == idx_d)) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= store_q[idx_d];
		end
	end

	// Column and tab phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			phase_q <= '0;
		end else if (cmd.col_clr) begin
			col_q   <= '0;
			phase_q <= '0;
		end else if (cmd.col_inc) begin
			col_q   <= col_q + 1'b1;
			phase_q <= (phase_q == PH_LAST) ? '0 : phase_q + 1'b1;
		end
	end

	// Pick the number of characters to emit
	always_comb begin
		case (cmd.len_sel)
			LEN_COL:  len_nxt = col_q;
			LEN_COL1: len_nxt = col_q + 1'b1;
			LEN_BRK:  len_nxt = (idx_q == '0) ? LC_I : idx_q + 1'b1;
			default:  len_nxt = col_q;
		endcase
	end

	// Next pointer value
	always_comb begin
		if (cmd.emit_start) begin
			idx_d = '0;
		end else if (cmd.idx_scan) begin
			idx_d = LC_M1;
		end else if (cmd.idx_dec) begin
			idx_d = idx_q - 1'b1;
		end else if (cmd.idx_inc) begin
			idx_d = idx_q + 1'b1;
		end else begin
			idx_d = idx_q;
		end
	end

	// Pointer and emit length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			len_q <= '0;
		end else begin
			idx_q <= idx_d;
			if (cmd.emit_start) begin
				len_q <= len_nxt;
			end
		end
	end

	// Output register: load an item, drop it once taken
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_char_q <= cmd.out_nl ? CH_NL : rd_data;
			last_q     <= cmd.out_nl;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign last_of_run = last_q;

	// Status
	always_comb begin
		sts.in_is_tab = (in_char == CH_TAB);
		sts.in_is_nl  = (in_char == CH_NL);
		sts.col_zero  = (col_q == '0);
		sts.col_last  = (col_q == LC_M1);
		sts.col_over  = (col_q >= LC_I);
		sts.tab_full  = (col_q >= LC_M1);
		sts.phase_end = (phase_q == PH_LAST);
		sts.scan_hit  = (idx_q == '0) || (rd_data == CH_BLANK);
		sts.emit_done = (idx_q == len_q);
		sts.len_short = (len_q < LC_I);
		sts.copy_last = (idx_q == LC_M1);
		sts.out_free  = out_free;
	end

endmodule

// ===== sv/lfte_ctrl.sv =====
`timescale 1ns / 1ps

module lfte_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lfte_pkg::dp_sts_t sts,
	output lfte_pkg::dp_cmd_t cmd
);
	import lfte_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   fold_q;
	logic   in_plain;

	assign in_plain = !sts.in_is_tab && !sts.in_is_nl;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Remember whether the current emit came from a fold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_q <= 1'b0;
		end else if (state_q == ST_IDLE && in_valid) begin
			fold_q <= in_plain && sts.col_last;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.in_is_tab) begin
						state_nxt = ST_TAB;
					end else if (sts.in_is_nl) begin
						state_nxt = sts.col_zero ? ST_IDLE : ST_EMIT;
					end else if (sts.col_last) begin
						state_nxt = ST_SCAN;
					end
				end
			end
			ST_TAB: begin
				if (sts.phase_end) begin
					state_nxt = sts.tab_full ? ST_EMIT : ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (sts.scan_hit) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free && sts.emit_done) begin
					state_nxt = (fold_q && sts.len_short) ? ST_COPY : ST_IDLE;
				end
			end
			ST_COPY: begin
				if (sts.copy_last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd      = '0;
		cmd.wr_sel  = WR_INPUT;
		cmd.len_sel = LEN_COL;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.store_we = 1'b1;
					cmd.wr_sel   = WR_INPUT;
					if (sts.in_is_nl) begin
						if (!sts.col_zero) begin
							cmd.emit_start = 1'b1;
							cmd.len_sel    = LEN_COL;
							cmd.col_clr    = 1'b1;
						end
					end else if (in_plain) begin
						if (sts.col_last) begin
							cmd.idx_scan = 1'b1;
						end else begin
							cmd.col_inc = 1'b1;
						end
					end
				end
			end
			ST_TAB: begin
				cmd.store_we = 1'b1;
				cmd.wr_sel   = WR_BLANK;
				cmd.col_inc  = 1'b1;
				if (sts.phase_end && sts.tab_full) begin
					cmd.emit_start = 1'b1;
					cmd.len_sel    = LEN_COL1;
					cmd.col_clr    = 1'b1;
				end
			end
			ST_SCAN: begin
				if (sts.scan_hit) begin
					cmd.emit_start = 1'b1;
					cmd.len_sel    = LEN_BRK;
					cmd.col_clr    = 1'b1;
				end else begin
					cmd.idx_dec = 1'b1;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.emit_done) begin
						cmd.out_nl = 1'b1;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			ST_COPY: begin
				cmd.store_we = 1'b1;
				cmd.wr_sel   = WR_COPY;
				cmd.col_inc  = 1'b1;
				cmd.idx_inc  = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== sv/line_fold_tab_expand.sv =====
`timescale 1ns / 1ps

// Channel | Ports                                       | Direction
// --------+---------------------------------------------+---------------
// input   | in_valid, in_stall, in_char                 | in (stall out)
// output  | out_valid, out_stall, out_char, last_of_run | out (stall in)
//
// An ordinary character is stored as is; a tab expands to blanks up to the next tab stop.
// An emitted line sends its stored characters followed by a newline.
// A fold first scans back over up to LINE_COLUMNS entries on the single store read port
// for a blank, and after the emit copies the moved characters to the start of the line.
// Reset clears the column, the sequencer and the output register; the store is not cleared.
// Output stall holds emission; input is stalled whenever the sequencer is busy.

module line_fold_tab_expand #(
	parameter int LINE_COLUMNS = lfte_pkg::LINE_COLUMNS_DEF,
	parameter int TAB_STOP     = lfte_pkg::TAB_STOP_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last_of_run
);
	import lfte_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer
	lfte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Line store, counters and output register
	lfte_dp #(
		.LINE_COLUMNS (LINE_COLUMNS),
		.TAB_STOP     (TAB_STOP)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_char     (in_char),
		.cmd         (cmd),
		.sts         (sts),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

	// Never overwrite an item that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output item overwritten while stalled");

	// The last item of a run is always a newline
	a_last_is_nl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_of_run) |-> (out_char == CH_NL))
		else $error("last item of a run is not a newline");

	// Column stays inside the line while waiting for input
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !sts.col_over)
		else $error("column out of range while idle");

endmodule
